>>> rtl/fat_short_name_converter_assert.svh
// Assertion macros shared by the short name converter modules.
`ifndef FAT_SHORT_NAME_CONVERTER_ASSERT_SVH
`define FAT_SHORT_NAME_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

`define FSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define FSN_ASSERT(lbl, prop, msg)

`define FSN_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/fat_sn_pkg.sv
// Types, constants and helper functions of the FAT short name converter.
package fat_sn_pkg;

  localparam int NameBytes     = 11;
  localparam int BaseMax       = 8;
  localparam int ExtMax        = 3;
  localparam int MaxChars      = 12;
  localparam int QueueDepthDef = 2;

  localparam logic [7:0] DeletedMark  = 8'hE5;
  localparam logic [7:0] DeletedSubst = 8'h05;
  localparam logic [7:0] PadByte      = 8'h20;
  localparam logic [7:0] DotChar      = 8'h2E;

  typedef struct packed {
    logic [NameBytes-1:0][7:0] bytes;
    logic                      err;
  } name_rec_t;

  function automatic logic is_bad_char(input logic [7:0] c);
    logic bad;
    bad = (c <= PadByte);
    unique case (c)
      8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B,
      8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: bad = 1'b1;
      default: ;
    endcase
    return bad;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

endpackage

>>> rtl/fat_sn_front.sv
// Front end: checks each name byte and builds the short name record.
`include "fat_short_name_converter_assert.svh"

module fat_sn_front
  import fat_sn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_char_code,
  input  logic      in_end_of_name,
  input  logic      q_full,
  output logic      rec_push,
  output name_rec_t rec_data
);

  logic [NameBytes-1:0][7:0] buf_r, buf_nxt;
  logic [3:0] wp_r, wp_nxt;
  logic [3:0] cs_r, cs_nxt;
  logic [3:0] base_r, base_nxt;
  logic [2:0] ext_r, ext_nxt;
  logic       dot_r, dot_nxt;
  logic       fail_r, fail_nxt;

  logic       accept;
  logic       first;
  logic       store;
  logic [7:0] cc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign rec_push = accept && in_end_of_name;
  assign rec_data.bytes = buf_r;
  assign rec_data.err   = fail_r || (cs_r == 4'd0);
  assign first = (cs_r == 4'd0);

  always_comb begin
    buf_nxt  = buf_r;
    wp_nxt   = wp_r;
    cs_nxt   = cs_r;
    base_nxt = base_r;
    ext_nxt  = ext_r;
    dot_nxt  = dot_r;
    fail_nxt = fail_r;
    store    = 1'b0;
    cc       = in_char_code;
    if (accept && in_end_of_name) begin
      buf_nxt  = {NameBytes{PadByte}};
      wp_nxt   = '0;
      cs_nxt   = '0;
      base_nxt = '0;
      ext_nxt  = '0;
      dot_nxt  = 1'b0;
      fail_nxt = 1'b0;
    end else if (accept && !fail_r) begin
      if (cs_r >= 4'(MaxChars)) begin
        fail_nxt = 1'b1;
      end else begin
        cs_nxt = cs_r + 4'd1;
        if (first && in_char_code == DeletedMark) begin
          cc    = DeletedSubst;
          store = 1'b1;
        end else if (in_char_code == DotChar) begin
          if (first || dot_r) begin
            fail_nxt = 1'b1;
          end else begin
            dot_nxt = 1'b1;
            wp_nxt  = 4'(BaseMax);
          end
        end else if (is_bad_char(in_char_code)) begin
          fail_nxt = 1'b1;
        end else begin
          store = 1'b1;
        end
      end
      if (store) begin
        if (dot_r && ext_r >= 3'(ExtMax)) begin
          fail_nxt = 1'b1;
        end else if (!dot_r && base_r >= 4'(BaseMax)) begin
          fail_nxt = 1'b1;
        end else begin
          if (dot_r) begin
            ext_nxt = ext_r + 3'd1;
          end else begin
            base_nxt = base_r + 4'd1;
          end
          if (wp_r < 4'(NameBytes)) begin
            buf_nxt[wp_r] = to_upper(cc);
            wp_nxt        = wp_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= {NameBytes{PadByte}};
      wp_r   <= '0;
      cs_r   <= '0;
      base_r <= '0;
      ext_r  <= '0;
      dot_r  <= 1'b0;
      fail_r <= 1'b0;
    end else begin
      buf_r  <= buf_nxt;
      wp_r   <= wp_nxt;
      cs_r   <= cs_nxt;
      base_r <= base_nxt;
      ext_r  <= ext_nxt;
      dot_r  <= dot_nxt;
      fail_r <= fail_nxt;
    end
  end

  `FSN_ASSERT(a_front_len_bound, cs_r <= 4'(MaxChars) && ext_r <= 3'(ExtMax), "Name counters out of range.")

endmodule

>>> rtl/fat_sn_queue.sv
// Short queue of finished name records between the front and back ends.
`include "fat_short_name_converter_assert.svh"

module fat_sn_queue
  import fat_sn_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  name_rec_t push_data,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output name_rec_t head
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  name_rec_t           mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == CntW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CntW'(do_push) - CntW'(do_pop);
    end
  end

  `FSN_ASSERT(a_queue_no_overflow, !(push && full), "Name record pushed into a full queue.")
  `FSN_ASSERT(a_queue_no_underflow, !(pop && !not_empty), "Name record popped from an empty queue.")

endmodule

>>> rtl/fat_sn_back.sv
// Back end: streams each name record out as 11 bytes or one error beat.
`include "fat_short_name_converter_assert.svh"

module fat_sn_back
  import fat_sn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       not_empty,
  input  name_rec_t  head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_name_byte,
  output logic       out_is_last,
  output logic       out_name_error
);

  logic [3:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       err_r;
  logic       load;
  logic       beat;
  logic       last;

  assign load = !valid_r || !out_stall;
  assign beat = load && not_empty;
  assign last = head.err || (idx_r == 4'(NameBytes - 1));
  assign pop  = beat && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= not_empty;
      end
      if (beat) begin
        idx_r <= last ? '0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      byte_r <= head.err ? 8'h00 : head.bytes[idx_r];
      last_r <= last;
      err_r  <= head.err;
    end
  end

  assign out_valid      = valid_r;
  assign out_name_byte  = byte_r;
  assign out_is_last    = last_r;
  assign out_name_error = err_r;

  `FSN_ASSERT(a_back_err_beat, !(valid_r && err_r) || (last_r && byte_r == 8'h00), "Malformed error beat.")
  `FSN_ASSERT_NEXT(a_back_idx_wrap, pop, idx_r == 4'd0, "Byte index did not restart after a name.")

endmodule

>>> rtl/fat_short_name_converter.sv
// A file name enters one byte per beat, followed by an end beat, at one beat per cycle with no
// stall unless the name queue is full. Each name yields 11 output beats (the padded, upper-case
// 8.3 name) or a single error beat, one per cycle unless out_stall holds the output register.
// Each finished record passes through the name queue and then the output register, and a
// two-entry name queue lets the next name enter while the previous one is still emitted.
// Top level of the FAT 8.3 short name converter.
module fat_short_name_converter
  import fat_sn_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_name,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_name_byte,
  output logic       out_is_last,
  output logic       out_name_error
);

  logic      q_full;
  logic      q_not_empty;
  logic      rec_push;
  logic      rec_pop;
  name_rec_t rec_data;
  name_rec_t rec_head;

  fat_sn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_end_of_name (in_end_of_name),
    .q_full         (q_full),
    .rec_push       (rec_push),
    .rec_data       (rec_data)
  );

  fat_sn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_push),
    .push_data (rec_data),
    .pop       (rec_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (rec_head)
  );

  fat_sn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .not_empty      (q_not_empty),
    .head           (rec_head),
    .pop            (rec_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_name_byte  (out_name_byte),
    .out_is_last    (out_is_last),
    .out_name_error (out_name_error)
  );

endmodule

>>> verif/short_name_check.sv
// Predicts the 8.3 short name beats of each file name and compares them with the converter output.
`timescale 1ns / 100ps

module short_name_check
  import fat_sn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_name,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_name_byte,
  input  logic       out_is_last,
  input  logic       out_name_error,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_last;
    logic       name_error;
  } short_name_beat_t;

  logic [7:0] name_buf [NameBytes];
  logic [3:0] wr_pos;
  logic [3:0] n_chars;
  logic [3:0] base_len;
  logic [2:0] ext_len;
  logic       dot_seen;
  logic       name_bad;

  short_name_beat_t name_beats_q[$];
  short_name_beat_t want;
  int               errs;
  int               n_results;

  function automatic logic forbidden_char(input logic [7:0] c);
    return (c <= PadByte) || (c inside {8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A,
                                        8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C,
                                        8'h5D, 8'h7C});
  endfunction

  task automatic clear_name();
    for (int k = 0; k < NameBytes; k++) name_buf[k] = PadByte;
    wr_pos   = '0;
    n_chars  = '0;
    base_len = '0;
    ext_len  = '0;
    dot_seen = 1'b0;
    name_bad = 1'b0;
  endtask

  task automatic take_name_char(input logic [7:0] c_in);
    logic [7:0] c;
    logic       first;
    c     = c_in;
    first = (n_chars == 0);
    if (n_chars >= MaxChars) begin
      name_bad = 1'b1;
      return;
    end
    n_chars = n_chars + 1'b1;
    if (first && c == DeletedMark) begin
      c = DeletedSubst;
    end else if (c == DotChar) begin
      if (first || dot_seen) begin
        name_bad = 1'b1;
      end else begin
        dot_seen = 1'b1;
        wr_pos   = 4'(BaseMax);
      end
      return;
    end else if (forbidden_char(c)) begin
      name_bad = 1'b1;
      return;
    end
    if (dot_seen) begin
      if (ext_len >= ExtMax) begin
        name_bad = 1'b1;
        return;
      end
      ext_len = ext_len + 1'b1;
    end else begin
      if (base_len >= BaseMax) begin
        name_bad = 1'b1;
        return;
      end
      base_len = base_len + 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    if (wr_pos < NameBytes) begin
      name_buf[wr_pos] = c;
      wr_pos = wr_pos + 1'b1;
    end
  endtask

  task automatic finish_name();
    if (name_bad || n_chars == 0) begin
      name_beats_q.push_back('{name_byte: 8'h00, is_last: 1'b1, name_error: 1'b1});
    end else begin
      for (int k = 0; k < NameBytes; k++)
        name_beats_q.push_back('{name_byte: name_buf[k], is_last: (k == NameBytes - 1),
                                 name_error: 1'b0});
    end
    clear_name();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_name();
      name_beats_q.delete();
      errs      = 0;
      n_results = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_end_of_name) finish_name();
        else if (!name_bad) take_name_char(in_char_code);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (name_beats_q.size() == 0) begin
          errs++;
          $display("%0t: result beat with none expected: byte %h last %b error %b", $time,
                   out_name_byte, out_is_last, out_name_error);
        end else begin
          want = name_beats_q.pop_front();
          if (out_name_byte !== want.name_byte || out_is_last !== want.is_last ||
              out_name_error !== want.name_error) begin
            errs++;
            $display("%0t: expected byte %h last %b error %b, got byte %h last %b error %b",
                     $time, want.name_byte, want.is_last, want.name_error,
                     out_name_byte, out_is_last, out_name_error);
          end
        end
      end
    end
    fail_count   <= errs;
    pending      <= name_beats_q.size();
    results_seen <= n_results;
  end

endmodule

>>> verif/tb.sv
// Testbench top: drives file names into the short name converter and reports the verdict.
`timescale 1ns / 100ps

module tb
  import fat_sn_pkg::*;
();

  localparam int QuietLimit  = 3000;
  localparam int RandomBeats = 470;
  localparam int TailCycles  = 30;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic [7:0] in_char_code   = 8'h00;
  logic       in_end_of_name = 1'b0;
  logic       out_stall      = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_name_byte;
  logic       out_is_last;
  logic       out_name_error;

  int fail_count;
  int pending;
  int results_seen;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int beats_sent     = 0;
  int names_sent     = 0;
  int quiet_cycles   = 0;

  int idle_tab [4] = '{0, 48, 0, 19};
  int stall_tab[4] = '{0, 0, 48, 19};

  logic [7:0] bad_tab[16] = '{8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B,
                              8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C};
  logic [7:0] punct_tab[17] = '{8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
                                8'h2D, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E,
                                8'h7F};

  always #5 clk = ~clk;

  fat_short_name_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_end_of_name(in_end_of_name),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_name_byte (out_name_byte),
    .out_is_last   (out_is_last),
    .out_name_error(out_name_error)
  );

  short_name_check u_short_name_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_end_of_name(in_end_of_name),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_name_byte (out_name_byte),
    .out_is_last   (out_is_last),
    .out_name_error(out_name_error),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
        $display("fat_short_name_converter test failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] legal_char();
    case ($urandom_range(4))
      0:       return 8'(8'h61 + $urandom_range(25));
      1:       return 8'(8'h41 + $urandom_range(25));
      2:       return 8'(8'h30 + $urandom_range(9));
      3:       return 8'(8'h80 + $urandom_range(127));
      default: return punct_tab[$urandom_range(16)];
    endcase
  endfunction

  task automatic add_legal(ref logic [7:0] nm[$], input int n);
    for (int i = 0; i < n; i++) nm.push_back(legal_char());
  endtask

  task automatic make_name(output logic [7:0] nm[$]);
    int kind;
    int pos;
    kind = $urandom_range(99);
    nm   = {};
    if (kind < 70) begin
      add_legal(nm, $urandom_range(1, 8));
      if ($urandom_range(9) == 0) nm[0] = DeletedMark;
      if ($urandom_range(9) < 6) begin
        nm.push_back(DotChar);
        add_legal(nm, $urandom_range(0, 3));
      end
    end else if (kind < 85) begin
      case ($urandom_range(6))
        0: add_legal(nm, $urandom_range(9, 11));
        1: begin
          add_legal(nm, $urandom_range(1, 8));
          nm.push_back(DotChar);
          add_legal(nm, $urandom_range(4, 5));
        end
        2: begin
          add_legal(nm, $urandom_range(1, 4));
          nm.push_back(DotChar);
          add_legal(nm, $urandom_range(1, 2));
          nm.push_back(DotChar);
          add_legal(nm, 1);
        end
        3: begin
          nm.push_back(DotChar);
          add_legal(nm, $urandom_range(1, 3));
        end
        4: begin
          add_legal(nm, $urandom_range(1, 8));
          pos = $urandom_range(0, nm.size() - 1);
          nm[pos] = $urandom_range(1) ? bad_tab[$urandom_range(15)]
                                      : 8'($urandom_range(0, 32));
        end
        5: begin
          add_legal(nm, 8);
          nm.push_back(DotChar);
          add_legal(nm, 3 + $urandom_range(1, 2));
        end
        default: ;
      endcase
    end else begin
      for (int i = $urandom_range(0, 14); i > 0; i--)
        nm.push_back(($urandom_range(3) == 0) ? DotChar : 8'($urandom_range(255)));
    end
  endtask

  // A beat stays on the port until the converter stops stalling.
  task automatic send_beat(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_name <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_name(input logic [7:0] nm[$]);
    foreach (nm[i]) send_beat(nm[i], 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1);
    names_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] nm[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    nm = {};
    send_name(nm);
    nm = {DeletedMark, 8'h7A, DotChar, 8'h61, 8'h7E};
    send_name(nm);
    nm = {DotChar, 8'h78};
    send_name(nm);
    nm = {8'h41, DotChar, 8'h42, DotChar};
    send_name(nm);
    nm = {8'h21, 8'h7F, 8'hFF, 8'h00, 8'h71};
    send_name(nm);
    nm = {PadByte};
    send_name(nm);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct <= stall_tab[p];
      while (beats_sent < (p + 1) * (RandomBeats / 4)) begin
        make_name(nm);
        send_name(nm);
      end
      drain_results();
    end

    repeat (TailCycles) @(posedge clk);
    if (pending != 0) $display("%0d expected result beats never arrived", pending);
    $display("Sent %0d names in %0d beats across four idle/stall phases;", names_sent,
             beats_sent);
    $display("checked %0d result beats, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("fat_short_name_converter test passed");
    end else begin
      $display("fat_short_name_converter test failed");
    end
    $finish;
  end

endmodule

>>> fat_short_name_converter.f
+incdir+rtl
rtl/fat_sn_pkg.sv
rtl/fat_sn_front.sv
rtl/fat_sn_queue.sv
rtl/fat_sn_back.sv
rtl/fat_short_name_converter.sv
verif/short_name_check.sv
verif/tb.sv
